### hdl/lrsp_pkg.sv
// types and constants shared by the log record stream parser
// no dependencies
package lrsp_pkg;

    localparam int unsigned LEN_W = 31;
    localparam int unsigned WORD_W = 32;

    localparam logic [LEN_W-1:0] MIN_RECORD = 31'd20;
    localparam logic [LEN_W-1:0] PAGED_HEADER = 31'd24;
    localparam logic [LEN_W-1:0] SIZE_FIELD_LEN = 31'd4;
    localparam logic [WORD_W-1:0] TYPE_INSERT = 32'd4;
    localparam logic [WORD_W-1:0] TYPE_DELETE = 32'd5;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_HEADER,
        PH_PAGE,
        PH_PAYLOAD,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PAYLOAD,
        KIND_STOP
    } t_kind;

    typedef enum logic [1:0] {
        STOP_SHORT_TAIL,
        STOP_SIZE_SMALL,
        STOP_LOG_OVERRUN,
        STOP_PAGE_OVERRUN
    } t_reason;

    // head of the byte queue as seen by the back end
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_qbeat;

endpackage

### hdl/lrsp_front.sv
// front end: accepts log bytes and queues them for the parser
// depends on lrsp_pkg
module lrsp_front
    import lrsp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_log_byte,
    output t_qbeat     o_head,
    input  logic       i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [7:0]       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready = (r_count != FULL_CNT);
    assign w_push = i_in_valid && o_in_ready;
    assign w_pop = i_pop && (r_count != '0);

    assign o_head.vld = (r_count != '0);
    assign o_head.data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_log_byte;
        end
    end

endmodule

### hdl/lrsp_back.sv
// back end: record parser state machine and result register
// depends on lrsp_pkg
module lrsp_back
    import lrsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LEN_W-1:0]  i_log_length,
    input  t_qbeat            i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [LEN_W-1:0]  o_record_start,
    output logic [LEN_W-1:0]  o_record_size,
    output logic [WORD_W-1:0] o_seq_number,
    output logic [WORD_W-1:0] o_txn_number,
    output logic [WORD_W-1:0] o_prior_seq,
    output logic [WORD_W-1:0] o_record_type,
    output logic [WORD_W-1:0] o_page_number,
    output logic [7:0]        o_payload_byte,
    output logic [1:0]        o_stop_reason,
    output logic              o_last
);

    // parser state
    t_phase              r_phase, n_phase;
    logic                r_stopped, n_stopped;
    logic [LEN_W-1:0]    r_start, n_start;
    logic [LEN_W-1:0]    r_pos, n_pos;
    logic [WORD_W-1:0]   r_shift, n_shift;
    logic [LEN_W-1:0]    r_size, n_size;
    logic [WORD_W-1:0]   r_seq, n_seq;
    logic [WORD_W-1:0]   r_txn, n_txn;
    logic [WORD_W-1:0]   r_prior, n_prior;
    logic [WORD_W-1:0]   r_type, n_type;
    logic [WORD_W-1:0]   r_page, n_page;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_kind, n_kind;
    logic [LEN_W-1:0]    r_o_start, n_o_start;
    logic [LEN_W-1:0]    r_o_size, n_o_size;
    logic [WORD_W-1:0]   r_o_seq, n_o_seq;
    logic [WORD_W-1:0]   r_o_txn, n_o_txn;
    logic [WORD_W-1:0]   r_o_prior, n_o_prior;
    logic [WORD_W-1:0]   r_o_type, n_o_type;
    logic [WORD_W-1:0]   r_o_page, n_o_page;
    logic [7:0]          r_o_byte, n_o_byte;
    logic [1:0]          r_reason, n_reason;
    logic                r_last, n_last;

    // per-beat decode
    logic                w_go;
    logic [1:0]          w_lane;
    logic                w_first;
    logic [WORD_W-1:0]   w_asm;
    logic [WORD_W-1:0]   w_type_now;
    logic                w_paged;
    logic                w_short;
    logic                w_rec_done;
    logic                w_halt;
    t_reason             w_reason;
    logic                w_emit;
    t_kind               w_kind;
    logic                w_last;
    logic                w_end;
    logic                w_adv;
    t_phase              w_phase_nxt;

    assign o_pop = i_head.vld && (!r_out_valid || i_out_ready);
    assign w_go = o_pop && !r_stopped;

    assign w_lane = r_pos[1:0];
    assign w_first = (r_pos == '0);
    assign w_asm = ((w_lane == 2'd0) ? '0 : r_shift)
                 | (WORD_W'(i_head.data) << {w_lane, 3'b000});
    // type word completes on the last header byte and is checked right away
    assign w_type_now = (r_pos == MIN_RECORD - 1'b1) ? w_asm : r_type;
    assign w_paged = (w_type_now == TYPE_INSERT) || (w_type_now == TYPE_DELETE);
    assign w_short = ({1'b0, r_start} + {1'b0, SIZE_FIELD_LEN}) > {1'b0, i_log_length};
    assign w_rec_done = ({1'b0, r_pos} + 32'd1) >= {1'b0, r_size};

    always_comb begin
        w_halt = 1'b0;
        w_reason = STOP_SHORT_TAIL;
        w_emit = 1'b0;
        w_kind = KIND_HEADER;
        w_last = 1'b0;
        w_end = 1'b0;
        w_adv = 1'b0;
        w_phase_nxt = r_phase;
        if (w_first && w_short) begin
            w_halt = 1'b1;
            w_reason = STOP_SHORT_TAIL;
        end else begin
            unique case (w_first ? PH_SIZE : r_phase)
                PH_SIZE: begin
                    w_adv = 1'b1;
                    if (w_lane == 2'd3) begin
                        if (w_asm[WORD_W-1] || (w_asm[LEN_W-1:0] < MIN_RECORD)) begin
                            w_halt = 1'b1;
                            w_reason = STOP_SIZE_SMALL;
                        end else if (({1'b0, r_start} + {1'b0, w_asm[LEN_W-1:0]})
                                     > {1'b0, i_log_length}) begin
                            w_halt = 1'b1;
                            w_reason = STOP_LOG_OVERRUN;
                        end else begin
                            w_phase_nxt = PH_HEADER;
                        end
                    end else begin
                        w_phase_nxt = PH_SIZE;
                    end
                end
                PH_HEADER: begin
                    if (r_pos < MIN_RECORD - 1'b1) begin
                        w_adv = 1'b1;
                    end else if (w_paged) begin
                        if (r_size < PAGED_HEADER) begin
                            w_halt = 1'b1;
                            w_reason = STOP_PAGE_OVERRUN;
                        end else begin
                            w_phase_nxt = PH_PAGE;
                            w_adv = 1'b1;
                        end
                    end else begin
                        w_emit = 1'b1;
                        w_kind = KIND_HEADER;
                        w_last = 1'b1;
                        if (r_size == MIN_RECORD) begin
                            w_end = 1'b1;
                        end else begin
                            w_phase_nxt = PH_SKIP;
                            w_adv = 1'b1;
                        end
                    end
                end
                PH_PAGE: begin
                    if (r_pos < PAGED_HEADER - 1'b1) begin
                        w_adv = 1'b1;
                    end else begin
                        w_emit = 1'b1;
                        w_kind = KIND_HEADER;
                        w_last = (r_size == PAGED_HEADER);
                        if (r_size == PAGED_HEADER) begin
                            w_end = 1'b1;
                        end else begin
                            w_phase_nxt = PH_PAYLOAD;
                            w_adv = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    w_emit = 1'b1;
                    w_kind = KIND_PAYLOAD;
                    w_last = w_rec_done;
                    w_end = w_rec_done;
                    w_adv = !w_rec_done;
                end
                PH_SKIP: begin
                    w_end = w_rec_done;
                    w_adv = !w_rec_done;
                end
                default: begin
                    w_adv = 1'b1;
                end
            endcase
        end
    end

    // next parser state
    always_comb begin
        n_phase = r_phase;
        n_stopped = r_stopped;
        n_start = r_start;
        n_pos = r_pos;
        n_shift = r_shift;
        n_size = r_size;
        n_seq = r_seq;
        n_txn = r_txn;
        n_prior = r_prior;
        n_type = r_type;
        n_page = r_page;
        if (w_go) begin
            if (w_halt) begin
                n_stopped = 1'b1;
            end else begin
                n_shift = w_asm;
                if (w_first) begin
                    n_seq = '0;
                    n_txn = '0;
                    n_prior = '0;
                    n_type = '0;
                    n_page = '0;
                end
                if (w_lane == 2'd3) begin
                    unique case (r_pos[LEN_W-1:2])
                        29'd0: n_size = w_asm[LEN_W-1:0];
                        29'd1: n_seq = w_asm;
                        29'd2: n_txn = w_asm;
                        29'd3: n_prior = w_asm;
                        29'd4: n_type = w_asm;
                        29'd5: n_page = (r_phase == PH_PAGE) ? w_asm : r_page;
                        default: ;
                    endcase
                end
                if (w_end) begin
                    n_start = r_start + r_size;
                    n_pos = '0;
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = w_phase_nxt;
                    if (w_adv) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
        end
    end

    // result register load
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind = r_kind;
        n_o_start = r_o_start;
        n_o_size = r_o_size;
        n_o_seq = r_o_seq;
        n_o_txn = r_o_txn;
        n_o_prior = r_o_prior;
        n_o_type = r_o_type;
        n_o_page = r_o_page;
        n_o_byte = r_o_byte;
        n_reason = r_reason;
        n_last = r_last;
        if (w_go && (w_halt || w_emit)) begin
            n_out_valid = 1'b1;
            n_o_start = r_start;
            if (w_halt) begin
                n_kind = KIND_STOP;
                n_o_size = '0;
                n_o_seq = '0;
                n_o_txn = '0;
                n_o_prior = '0;
                n_o_type = '0;
                n_o_page = '0;
                n_o_byte = '0;
                n_reason = w_reason;
                n_last = 1'b1;
            end else begin
                n_kind = w_kind;
                n_o_size = r_size;
                n_o_seq = r_seq;
                n_o_txn = r_txn;
                n_o_prior = r_prior;
                n_o_type = w_type_now;
                // page word completes on the same beat as the paged header result
                n_o_page = (r_phase == PH_PAGE) ? w_asm : r_page;
                n_o_byte = (w_kind == KIND_PAYLOAD) ? i_head.data : 8'd0;
                n_reason = STOP_SHORT_TAIL;
                n_last = w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_stopped <= 1'b0;
            r_start <= '0;
            r_pos <= '0;
            r_shift <= '0;
            r_size <= '0;
            r_seq <= '0;
            r_txn <= '0;
            r_prior <= '0;
            r_type <= '0;
            r_page <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_stopped <= n_stopped;
            r_start <= n_start;
            r_pos <= n_pos;
            r_shift <= n_shift;
            r_size <= n_size;
            r_seq <= n_seq;
            r_txn <= n_txn;
            r_prior <= n_prior;
            r_type <= n_type;
            r_page <= n_page;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_o_start <= n_o_start;
        r_o_size <= n_o_size;
        r_o_seq <= n_o_seq;
        r_o_txn <= n_o_txn;
        r_o_prior <= n_o_prior;
        r_o_type <= n_o_type;
        r_o_page <= n_o_page;
        r_o_byte <= n_o_byte;
        r_reason <= n_reason;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind = r_kind;
    assign o_record_start = r_o_start;
    assign o_record_size = r_o_size;
    assign o_seq_number = r_o_seq;
    assign o_txn_number = r_o_txn;
    assign o_prior_seq = r_o_prior;
    assign o_record_type = r_o_type;
    assign o_page_number = r_o_page;
    assign o_payload_byte = r_o_byte;
    assign o_stop_reason = r_reason;
    assign o_last = r_last;

endmodule

### hdl/log_record_stream_parser_top.sv
// Log record stream parser, top level.
// Input channel: one log byte per beat (i_in_valid / o_in_ready, i_log_byte).
// Output channel: one result per beat (o_out_valid / i_out_ready): a record
// header, a raw payload byte of an insert or delete record, or a stop with a
// coded reason. Payload results repeat the header fields of their record.
// Configuration: i_cfg_we writes i_cfg_data into the log length register in
// the same cycle; write it only while the parser is idle.
// Throughput: one byte per cycle while the receiver does not stall. An accepted byte
// is written into the front queue, then parsed from its head into the result register.
// The front queue holds QUEUE_DEPTH bytes; the parser takes the head byte
// whenever its result register is empty or being drained, so a stalled
// receiver fills the queue and then drops o_in_ready.
// Reset (synchronous, active low) clears the queue, the parser and the log
// length. After a stop, further bytes are accepted and discarded until reset.
// Depends on lrsp_pkg, lrsp_front and lrsp_back.
module log_record_stream_parser_top
    import lrsp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_log_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [LEN_W-1:0]  o_record_start,
    output logic [LEN_W-1:0]  o_record_size,
    output logic [WORD_W-1:0] o_seq_number,
    output logic [WORD_W-1:0] o_txn_number,
    output logic [WORD_W-1:0] o_prior_seq,
    output logic [WORD_W-1:0] o_record_type,
    output logic [WORD_W-1:0] o_page_number,
    output logic [7:0]        o_payload_byte,
    output logic [1:0]        o_stop_reason,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    logic [LEN_W-1:0] r_log_length;
    t_qbeat           w_head;
    logic             w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_length <= '0;
        end else if (i_cfg_we) begin
            r_log_length <= i_cfg_data;
        end
    end

    lrsp_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_log_byte (i_log_byte),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    lrsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_log_length   (r_log_length),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_record_start (o_record_start),
        .o_record_size  (o_record_size),
        .o_seq_number   (o_seq_number),
        .o_txn_number   (o_txn_number),
        .o_prior_seq    (o_prior_seq),
        .o_record_type  (o_record_type),
        .o_page_number  (o_page_number),
        .o_payload_byte (o_payload_byte),
        .o_stop_reason  (o_stop_reason),
        .o_last         (o_last)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// testbench for log_record_stream_parser_top: streams whole log records, predicts
// header, payload and stop beats in a scoreboard class and checks every output beat
// depends on lrsp_pkg and log_record_stream_parser_top
module tb;
    import lrsp_pkg::*;

    localparam int REG_LOG_LENGTH = 0;
    localparam int DRAIN_GAP = 12;
    localparam int STALL_LIMIT = 500;
    localparam int LOG_TARGET = 500;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        t_kind             kind;
        logic [LEN_W-1:0]  start;
        logic [LEN_W-1:0]  rec_size;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] txn;
        logic [WORD_W-1:0] prior;
        logic [WORD_W-1:0] rtype;
        logic [WORD_W-1:0] page;
        logic [7:0]        data;
        t_reason           reason;
        logic              last;
    } t_parse_result;

    class parse_scoreboard;
        logic [LEN_W-1:0]  log_len;
        t_phase            phase;
        bit                halted;
        logic [LEN_W-1:0]  cur_start;
        logic [LEN_W-1:0]  rec_pos;
        logic [WORD_W-1:0] word_acc;
        logic [WORD_W-1:0] size_w, seq_w, txn_w, prior_w, type_w, page_w;
        t_parse_result     results_due[$];
        int                failures;
        int                checked;

        function new();
            log_len = '0;
            phase = PH_SIZE;
            halted = 1'b0;
            cur_start = '0;
            rec_pos = '0;
            word_acc = '0;
            size_w = '0;
            seq_w = '0;
            txn_w = '0;
            prior_w = '0;
            type_w = '0;
            page_w = '0;
            failures = 0;
            checked = 0;
        endfunction

        function void write_register(int index, logic [LEN_W-1:0] value);
            if (index == REG_LOG_LENGTH) log_len = value;
        endfunction

        function void queue_record_beat(t_kind kind, logic [7:0] data, logic last);
            t_parse_result r;
            r.kind = kind;
            r.start = cur_start;
            r.rec_size = size_w[LEN_W-1:0];
            r.seq = seq_w;
            r.txn = txn_w;
            r.prior = prior_w;
            r.rtype = type_w;
            r.page = page_w;
            r.data = data;
            r.reason = STOP_SHORT_TAIL;
            r.last = last;
            results_due = {results_due, r};
        endfunction

        function void queue_stop(t_reason reason);
            t_parse_result r;
            halted = 1'b1;
            r = '0;
            r.kind = KIND_STOP;
            r.start = cur_start;
            r.reason = reason;
            r.last = 1'b1;
            results_due = {results_due, r};
        endfunction

        function void close_record();
            cur_start = cur_start + size_w[LEN_W-1:0];
            rec_pos = '0;
            phase = PH_SIZE;
        endfunction

        // advance the parser by one accepted log byte
        function void note_byte(logic [7:0] b);
            logic [LEN_W-1:0] pos;
            logic [1:0]       lane;
            logic             paged;
            pos = rec_pos;
            lane = pos[1:0];
            if (halted) return;
            if (pos == '0) begin
                if (64'(cur_start) + 64'd4 > 64'(log_len)) begin
                    queue_stop(STOP_SHORT_TAIL);
                    return;
                end
                size_w = '0;
                seq_w = '0;
                txn_w = '0;
                prior_w = '0;
                type_w = '0;
                page_w = '0;
                phase = PH_SIZE;
            end
            word_acc = (lane == 2'd0 ? 32'd0 : word_acc) | ({24'd0, b} << (8 * lane));
            case (phase)
                PH_SIZE: begin
                    if (lane == 2'd3) begin
                        size_w = word_acc;
                        if (size_w[31] || size_w < {1'b0, MIN_RECORD}) begin
                            queue_stop(STOP_SIZE_SMALL);
                            return;
                        end
                        if (64'(cur_start) + 64'(size_w) > 64'(log_len)) begin
                            queue_stop(STOP_LOG_OVERRUN);
                            return;
                        end
                        phase = PH_HEADER;
                    end
                    rec_pos++;
                end
                PH_HEADER: begin
                    if (lane == 2'd3) begin
                        case (pos >> 2)
                            1: seq_w = word_acc;
                            2: txn_w = word_acc;
                            3: prior_w = word_acc;
                            default: type_w = word_acc;
                        endcase
                    end
                    if (pos + 1 < MIN_RECORD) begin
                        rec_pos++;
                        return;
                    end
                    paged = (type_w == TYPE_INSERT) || (type_w == TYPE_DELETE);
                    if (paged) begin
                        if (size_w < {1'b0, PAGED_HEADER}) begin
                            queue_stop(STOP_PAGE_OVERRUN);
                            return;
                        end
                        phase = PH_PAGE;
                        rec_pos++;
                        return;
                    end
                    queue_record_beat(KIND_HEADER, 8'd0, 1'b1);
                    if (size_w == {1'b0, MIN_RECORD}) begin
                        close_record();
                    end else begin
                        phase = PH_SKIP;
                        rec_pos++;
                    end
                end
                PH_PAGE: begin
                    if (pos + 1 < PAGED_HEADER) begin
                        rec_pos++;
                        return;
                    end
                    page_w = word_acc;
                    queue_record_beat(KIND_HEADER, 8'd0, size_w == {1'b0, PAGED_HEADER});
                    if (size_w == {1'b0, PAGED_HEADER}) begin
                        close_record();
                    end else begin
                        phase = PH_PAYLOAD;
                        rec_pos++;
                    end
                end
                PH_PAYLOAD: begin
                    if ({1'b0, pos} + 32'd1 >= size_w) begin
                        queue_record_beat(KIND_PAYLOAD, b, 1'b1);
                        close_record();
                    end else begin
                        queue_record_beat(KIND_PAYLOAD, b, 1'b0);
                        rec_pos++;
                    end
                end
                default: begin
                    if ({1'b0, pos} + 32'd1 >= size_w) close_record();
                    else rec_pos++;
                end
            endcase
        endfunction

        function void check_result(t_parse_result got);
            t_parse_result want;
            checked++;
            if (results_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected output beat %0d: kind %0d start %0d",
                             checked, got.kind, got.start);
                return;
            end
            want = results_due.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch on output beat %0d (expected/actual):", checked);
                    $display("  kind %0d/%0d start %0d/%0d size %0d/%0d last %0b/%0b",
                             want.kind, got.kind, want.start, got.start,
                             want.rec_size, got.rec_size, want.last, got.last);
                    $display("  seq %h/%h txn %h/%h prior %h/%h type %h/%h",
                             want.seq, got.seq, want.txn, got.txn,
                             want.prior, got.prior, want.rtype, got.rtype);
                    $display("  page %h/%h byte %h/%h reason %0d/%0d",
                             want.page, got.page, want.data, got.data,
                             want.reason, got.reason);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_log_byte = 8'd0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_kind;
    logic [LEN_W-1:0]  o_record_start;
    logic [LEN_W-1:0]  o_record_size;
    logic [WORD_W-1:0] o_seq_number;
    logic [WORD_W-1:0] o_txn_number;
    logic [WORD_W-1:0] o_prior_seq;
    logic [WORD_W-1:0] o_record_type;
    logic [WORD_W-1:0] o_page_number;
    logic [7:0]        o_payload_byte;
    logic [1:0]        o_stop_reason;
    logic              o_last;
    logic              i_cfg_we = 1'b0;
    logic [LEN_W-1:0]  i_cfg_data = '0;

    parse_scoreboard   board = new();
    bit                tx_steady = 1'b0;
    bit                rx_steady = 1'b0;
    logic [LEN_W-1:0]  log_pos = '0;

    log_record_stream_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_log_byte     (i_log_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_record_start (o_record_start),
        .o_record_size  (o_record_size),
        .o_seq_number   (o_seq_number),
        .o_txn_number   (o_txn_number),
        .o_prior_seq    (o_prior_seq),
        .o_record_type  (o_record_type),
        .o_page_number  (o_page_number),
        .o_payload_byte (o_payload_byte),
        .o_stop_reason  (o_stop_reason),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_log_byte <= value;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_byte(value);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
    endtask

    // whole record: size, four header words, then body bytes (page and payload or skipped)
    task automatic send_record(input logic [31:0] rec_size, input logic [31:0] rtype,
                               input logic [31:0] seq, input logic [31:0] txn,
                               input logic [31:0] prior);
        send_word(rec_size);
        send_word(seq);
        send_word(txn);
        send_word(prior);
        send_word(rtype);
        for (int n = 20; n < rec_size; n++) send_byte(8'($urandom_range(0, 255)));
        log_pos = log_pos + rec_size[LEN_W-1:0];
    endtask

    // sender holds off until every beat is out, then the register is written
    task automatic set_log_length(input logic [LEN_W-1:0] value);
        i_in_valid <= 1'b0;
        while (board.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.write_register(REG_LOG_LENGTH, value);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1: return TYPE_INSERT;
            2, 3: return TYPE_DELETE;
            4: return 32'h0000_0000;
            5: return 32'hFFFF_FFFF;
            6: return 32'($urandom_range(0, 3));
            7: return 32'($urandom_range(6, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_size(input logic [31:0] rtype);
        logic big;
        big = ($urandom_range(0, 7) == 0);
        if (rtype == TYPE_INSERT || rtype == TYPE_DELETE)
            return 32'd24 + (big ? $urandom_range(0, 100) : $urandom_range(0, 12));
        return 32'd20 + (big ? $urandom_range(0, 100) : $urandom_range(0, 8));
    endfunction

    // one malformed or truncated record ends parsing for the rest of the run
    task automatic send_breaking_record();
        logic [31:0]      rec_size;
        logic [LEN_W-1:0] room;
        case (t_reason'($urandom_range(0, 3)))
            STOP_SHORT_TAIL: begin
                if ($urandom_range(0, 3) == 0 && log_pos != '0) set_log_length('0);
                else set_log_length(log_pos + LEN_W'($urandom_range(0, 3)));
                send_byte(8'($urandom_range(0, 255)));
            end
            STOP_SIZE_SMALL: begin
                set_log_length(LEN_MAX);
                if ($urandom_range(0, 1) == 0) rec_size = {1'b1, 31'($urandom)};
                else rec_size = 32'($urandom_range(0, 19));
                send_word(rec_size);
            end
            STOP_LOG_OVERRUN: begin
                room = LEN_W'($urandom_range(20, 200));
                set_log_length(log_pos + room);
                if ($urandom_range(0, 3) == 0) rec_size = 32'h7FFF_FFFF;
                else rec_size = {1'b0, room} + 32'($urandom_range(1, 1000));
                send_word(rec_size);
            end
            default: begin
                set_log_length(LEN_MAX);
                send_word(32'($urandom_range(20, 23)));
                send_word(pick_word());
                send_word(pick_word());
                send_word(pick_word());
                send_word($urandom_range(0, 1) == 0 ? TYPE_INSERT : TYPE_DELETE);
            end
        endcase
        // later bytes are swallowed without output
        repeat ($urandom_range(4, 16)) send_byte(8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;
    endtask

    initial begin : drain_results
        t_parse_result got;
        int unsigned   stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.kind = t_kind'(o_kind);
            got.start = o_record_start;
            got.rec_size = o_record_size;
            got.seq = o_seq_number;
            got.txn = o_txn_number;
            got.prior = o_prior_seq;
            got.rtype = o_record_type;
            got.page = o_page_number;
            got.data = o_payload_byte;
            got.reason = t_reason'(o_stop_reason);
            got.last = o_last;
            board.check_result(got);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : run_log
        logic [31:0]      sizes[4];
        logic [31:0]      types[4];
        int unsigned      count;
        logic [LEN_W-1:0] total;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_log_length('0);
        set_log_length(LEN_MAX);

        // smallest records, all-zero and all-one fields, paged without and with payload
        send_record(32'd20, 32'h0, 32'h0, 32'h0, 32'h0);
        send_record(32'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_record(32'd24, TYPE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
        send_record(32'd26, TYPE_DELETE, $urandom, $urandom, $urandom);
        send_record(32'd23, 32'd6, $urandom, $urandom, $urandom);
        // upper type bits set: not paged, body skipped
        send_record(32'd24, 32'h0000_0104, $urandom, $urandom, $urandom);

        while (log_pos < LOG_TARGET) begin
            count = $urandom_range(1, 4);
            total = '0;
            for (int i = 0; i < count; i++) begin
                types[i] = pick_type();
                sizes[i] = pick_size(types[i]);
                total = total + sizes[i][LEN_W-1:0];
            end
            case ($urandom_range(0, 3))
                0: set_log_length(LEN_MAX);
                1: set_log_length(log_pos + total);
                2: set_log_length(log_pos + total + LEN_W'($urandom_range(0, 3)));
                default: set_log_length(log_pos + total + LEN_W'($urandom_range(0, 1 << 20)));
            endcase
            for (int i = 0; i < count; i++) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
                send_record(sizes[i], types[i], pick_word(), pick_word(), pick_word());
            end
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_breaking_record();

        while (board.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (board.failures == 0 && board.results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hdl/lrsp_pkg.sv
hdl/lrsp_front.sv
hdl/lrsp_back.sv
hdl/log_record_stream_parser_top.sv
tb/tb.sv
